// ===== src/crt_pkg.sv =====
package crt_pkg;

  // Array sizes
  localparam int MAX_PARTITIONS = 16;
  localparam int MAX_VERTICES   = 64;
  localparam int LABEL_BITS     = 6;

  // Field widths
  localparam int PART_BITS = 4;
  localparam int VTX_BITS  = 6;
  localparam int LAB_BITS  = 6;
  localparam int CNT_BITS  = 5;
  localparam int NUM_BITS  = 7;
  localparam int CFG_BITS  = 7;
  localparam int CIDX_BITS = 2;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } op_t;

  typedef enum logic [CIDX_BITS-1:0] {
    REG_FIRST_SELECTED  = 2'd0,
    REG_LAST_SELECTED   = 2'd1,
    REG_MIN_AGREE       = 2'd2,
    REG_VERTICES_IN_USE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_LOAD,
    TOK_ROW,
    TOK_COL
  } tok_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2
  } seq_state_t;

  // What travels from cell to cell each cycle that the chain advances
  typedef struct packed {
    tok_kind_t             kind;
    logic                  pass;   // 0: scan pass, 1: emit pass
    logic [VTX_BITS-1:0]   addr;   // vertex / column
    logic [PART_BITS-1:0]  part;   // load target partition
    logic [LABEL_BITS-1:0] label;  // load data
    logic [CNT_BITS-1:0]   count;  // running agreement count
  } token_t;

endpackage

// ===== src/coassociation_row_threshold.sv =====
// Coassociation rows with agreement threshold, chain of per-partition cells.
// Label load: accepted at the input, no result.
// Row: input not ready until every vertex in use has entered as a column twice;
//   results come from the emit pass, one result per cycle unless m_tready stalls.
//   Rate is set by one column entering the cell chain per cycle while not stalled, twice per row.
// Reset (rst, synchronous): configuration and sequencer to defaults, chain and output emptied; labels undefined.
module coassociation_row_threshold import crt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CIDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // partition[3:0], vertex[9:4], label[15:10], row[21:16]
  input  logic                 s_tuser,   // operation
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // column[5:0], agreement[10:6], kept[11]
  output logic                 m_tlast    // last
);

  // configuration
  logic [PART_BITS-1:0] first_selected;
  logic [PART_BITS-1:0] last_selected;
  logic [CNT_BITS-1:0]  min_agree;
  logic [NUM_BITS-1:0]  vertices_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_selected  <= '0;
      last_selected   <= PART_BITS'(15);
      min_agree       <= CNT_BITS'(8);
      vertices_in_use <= NUM_BITS'(MAX_VERTICES);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_SELECTED:  first_selected  <= cfg_data[PART_BITS-1:0];
        REG_LAST_SELECTED:   last_selected   <= cfg_data[PART_BITS-1:0];
        REG_MIN_AGREE:       min_agree       <= cfg_data[CNT_BITS-1:0];
        REG_VERTICES_IN_USE: vertices_in_use <= cfg_data[NUM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // last column index: zero acts as one vertex, too many acts as the maximum
  logic [VTX_BITS-1:0] last_col;
  always_comb begin
    if (vertices_in_use == '0) begin
      last_col = '0;
    end else if (vertices_in_use > NUM_BITS'(MAX_VERTICES)) begin
      last_col = VTX_BITS'(MAX_VERTICES - 1);
    end else begin
      last_col = VTX_BITS'(vertices_in_use - NUM_BITS'(1));
    end
  end

  // input fields
  op_t                  in_op;
  logic [PART_BITS-1:0] in_part;
  logic [VTX_BITS-1:0]  in_vertex;
  logic [LAB_BITS-1:0]  in_label;
  logic [VTX_BITS-1:0]  in_row;
  assign in_op     = op_t'(s_tuser);
  assign in_part   = s_tdata[3:0];
  assign in_vertex = s_tdata[9:4];
  assign in_label  = s_tdata[15:10];
  assign in_row    = s_tdata[21:16];

  // whole chain and the output stage advance together; stall on a held result
  logic en;
  assign en = !m_tvalid || m_tready;

  // sequencer: load tokens, or a row token then columns for the scan pass and for the emit pass
  seq_state_t          state, state_next;
  logic [VTX_BITS-1:0] col, col_next;
  token_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
    end
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    head       = '{kind: TOK_NONE, pass: 1'b0, addr: '0, part: '0, label: '0, count: '0};
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = en;
        if (s_tvalid) begin
          if (in_op == OP_LOAD) begin
            head.kind  = TOK_LOAD;
            head.addr  = in_vertex;
            head.part  = in_part;
            head.label = in_label[LABEL_BITS-1:0];
          end else begin
            head.kind = TOK_ROW;
            head.addr = in_row;
            if (en) begin
              state_next = ST_PASS1;
              col_next   = '0;
            end
          end
        end
      end
      ST_PASS1, ST_PASS2: begin
        head.kind = TOK_COL;
        head.pass = (state == ST_PASS2);
        head.addr = col;
        if (en) begin
          if (col == last_col) begin
            col_next   = '0;
            state_next = (state == ST_PASS1) ? ST_PASS2 : ST_IDLE;
          end else begin
            col_next = col + VTX_BITS'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // chain of partition cells; each adds its own agreement to a passing column
  token_t link [MAX_PARTITIONS+1];
  assign link[0] = head;

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    crt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (PART_BITS'(g)),
      .first_sel (first_selected),
      .last_sel  (last_selected),
      .tok_in    (link[g]),
      .tok_out   (link[g+1])
    );
  end

  // threshold, best-column fallback and output register
  logic [VTX_BITS-1:0] out_column;
  logic [CNT_BITS-1:0] out_agreement;
  logic                out_kept;

  crt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tok       (link[MAX_PARTITIONS]),
    .min_agree (min_agree),
    .last_col  (last_col),
    .valid     (m_tvalid),
    .column    (out_column),
    .agreement (out_agreement),
    .kept      (out_kept),
    .last      (m_tlast)
  );

  assign m_tdata = {4'b0, out_kept, out_agreement, out_column};

endmodule

// ===== src/crt_cell.sv =====
module crt_cell import crt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [PART_BITS-1:0] idx,
  input  logic [PART_BITS-1:0] first_sel,
  input  logic [PART_BITS-1:0] last_sel,
  input  token_t               tok_in,
  output token_t               tok_out
);

  logic [LABEL_BITS-1:0] mem [MAX_VERTICES];
  logic [LABEL_BITS-1:0] rdata;
  logic [LABEL_BITS-1:0] row_label;
  token_t                tok_q;
  logic                  selected;
  logic                  match;

  // one partition's labels, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (tok_in.kind == TOK_LOAD && tok_in.part == idx) begin
        mem[tok_in.addr] <= tok_in.label;
      end
      rdata <= mem[tok_in.addr];
    end
  end

  // only the token kind needs a reset; the payload follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.kind <= TOK_NONE;
    end else if (en) begin
      tok_q <= tok_in;
    end
  end

  // label of the row vertex, held for the column tokens behind it
  always_ff @(posedge clk) begin
    if (en && tok_q.kind == TOK_ROW) begin
      row_label <= rdata;
    end
  end

  always_comb begin
    selected = (idx >= first_sel) && (idx <= last_sel);
    match    = (tok_q.kind == TOK_COL) && selected && (rdata == row_label);
    tok_out  = tok_q;
    if (match && tok_q.count != CNT_MAX) begin
      tok_out.count = tok_q.count + CNT_BITS'(1);
    end
  end

endmodule

// ===== src/crt_scan.sv =====
module crt_scan import crt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  token_t              tok,
  input  logic [CNT_BITS-1:0] min_agree,
  input  logic [VTX_BITS-1:0] last_col,
  output logic                valid,
  output logic [VTX_BITS-1:0] column,
  output logic [CNT_BITS-1:0] agreement,
  output logic                kept,
  output logic                last
);

  logic [CNT_BITS-1:0] best_v;
  logic [VTX_BITS-1:0] best_j;
  logic                any_kept;
  logic                any_kept_next;
  logic                hit;
  logic                pass_thr;
  logic                fallback;
  logic                first_col;

  always_comb begin
    hit       = (tok.kind == TOK_COL);
    pass_thr  = (tok.count >= min_agree);
    first_col = (tok.addr == '0);
    any_kept_next = (first_col ? 1'b0 : any_kept) | (pass_thr && tok.count != '0);
    fallback  = !any_kept && (tok.addr == best_j);
  end

  // scan pass: best column and whether anything survives
  always_ff @(posedge clk) begin
    if (en && hit && !tok.pass) begin
      if (first_col || tok.count > best_v) begin
        best_v <= tok.count;
        best_j <= tok.addr;
      end
      any_kept <= any_kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= hit && tok.pass;
    end
  end

  // emit pass: same counts again, now with the fallback known
  always_ff @(posedge clk) begin
    if (en) begin
      column    <= tok.addr;
      agreement <= (pass_thr || fallback) ? tok.count : '0;
      kept      <= pass_thr || fallback;
      last      <= (tok.addr == last_col);
    end
  end

endmodule
